>>> rtl/atan2_binary_angle_macros.svh
// Assertion macros for the angle extractor.
`ifndef ATAN2_BINARY_ANGLE_MACROS_SVH
`define ATAN2_BINARY_ANGLE_MACROS_SVH
`ifndef ASSERT_OFF
`define A2BA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define A2BA_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define A2BA_ASSERT(lbl, clk, rstn, prop)
`define A2BA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

>>> rtl/a2ba_pkg.sv
// Shared widths, constants, types and the Q30 multiply of the angle extractor.
package a2ba_pkg;
  localparam int IW = 16;
  localparam int MW = IW + 1;
  localparam int EW = IW + 2;
  localparam int QW = 31;
  localparam int DW = 30;
  localparam int AW = 17;

  localparam logic signed [AW-1:0] ANG_PI = AW'(32768);
  localparam logic signed [AW-1:0] ANG_HALF_PI = AW'(16384);
  localparam logic signed [AW-1:0] ANG_QUARTER_PI = AW'(8192);

  localparam logic [29:0] SCALE_Q16 = 30'd683565276;
  localparam logic [28:0] RAT_C_Q30 = 29'd300647711;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic signed [32:0] POLY_C0 = 33'sd1073597943;
  localparam logic signed [32:0] POLY_C1 = -33'sd354656388;
  localparam logic signed [32:0] POLY_C2 = 33'sd193424926;
  localparam logic signed [32:0] POLY_C3 = -33'sd91410863;
  localparam logic signed [32:0] POLY_C4 = 33'sd22371508;

  typedef enum logic [1:0] {
    OFF_NONE  = 2'd0,
    OFF_PLUS  = 2'd1,
    OFF_MINUS = 2'd2
  } off_e;

  typedef struct packed {
    logic special;
    logic signed [AW-1:0] spec_angle;
    off_e off;
    logic yneg;
    logic neg;
  } side_t;

  function automatic logic signed [32:0] mulq(input logic signed [32:0] a,
                                              input logic [30:0] b);
    logic [31:0] am;
    logic [62:0] pr;
    logic [32:0] m;
    am = a[32] ? 32'(-a) : a[31:0];
    pr = 63'(am) * 63'(b);
    m = 33'(pr >> 30);
    return a[32] ? -$signed(m) : $signed(m);
  endfunction
endpackage

>>> rtl/a2ba_prep.sv
// Input stage: special cases, octant fold and operand magnitudes for the ratio.
module a2ba_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [a2ba_pkg::IW-1:0] x_i,
  input  logic [a2ba_pkg::IW-1:0] y_i,
  output logic                 valid_o,
  output logic [a2ba_pkg::MW-1:0] num_o,
  output logic [a2ba_pkg::MW-1:0] den_o,
  output a2ba_pkg::side_t      side_o
);
  import a2ba_pkg::*;

  logic signed [EW-1:0] x, y, ax, ay, nv, dv;
  logic [MW-1:0] num_d, num_q, den_d, den_q;
  side_t side_d, side_q;
  logic valid_q;

  always_comb begin
    x = EW'($signed(x_i));
    y = EW'($signed(y_i));
    ax = x[EW-1] ? -x : x;
    ay = y[EW-1] ? -y : y;
    side_d.special = (y == '0);
    side_d.yneg = y[EW-1];
    if (x > 0) begin
      side_d.spec_angle = ANG_HALF_PI;
    end else if (x < 0) begin
      side_d.spec_angle = -ANG_HALF_PI;
    end else begin
      side_d.spec_angle = '0;
    end
    if (ax <= ay) begin
      nv = x;
      dv = y;
      side_d.off = OFF_NONE;
    end else if (x[EW-1] == y[EW-1]) begin
      nv = x - y;
      dv = x + y;
      side_d.off = OFF_PLUS;
    end else begin
      nv = x + y;
      dv = y - x;
      side_d.off = OFF_MINUS;
    end
    side_d.neg = nv[EW-1] ^ dv[EW-1];
    num_d = nv[EW-1] ? MW'(-nv) : MW'(nv);
    den_d = dv[EW-1] ? MW'(-dv) : MW'(dv);
    if (side_d.special) begin
      den_d = MW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      den_q <= den_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o = num_q;
  assign den_o = den_q;
  assign side_o = side_q;
endmodule

>>> rtl/a2ba_ratio_div.sv
// Pipelined restoring divider giving the folded ratio in Q1.30, one bit per stage.
module a2ba_ratio_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [a2ba_pkg::MW-1:0] num_i,
  input  logic [a2ba_pkg::MW-1:0] den_i,
  input  a2ba_pkg::side_t      side_i,
  output logic                 valid_o,
  output logic [a2ba_pkg::QW-1:0] ratio_o,
  output a2ba_pkg::side_t      side_o
);
  import a2ba_pkg::*;

  logic [MW-1:0] rem_q [QW];
  logic [MW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];
  side_t side_q [QW];
  logic [QW-1:0] vld_q;

  logic [MW-1:0] rem_d [QW];
  logic [QW-1:0] quo_d [QW];

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      logic [MW:0] t;
      logic [MW-1:0] dd;
      logic [QW-1:0] qq;
      if (j == 0) begin
        t = {1'b0, num_i};
        dd = den_i;
        qq = '0;
      end else begin
        t = {rem_q[j-1], 1'b0};
        dd = den_q[j-1];
        qq = quo_q[j-1];
      end
      if (t >= {1'b0, dd}) begin
        rem_d[j] = MW'(t - {1'b0, dd});
        quo_d[j] = {qq[QW-2:0], 1'b1};
      end else begin
        rem_d[j] = t[MW-1:0];
        quo_d[j] = {qq[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < QW; j++) begin
        rem_q[j] <= rem_d[j];
        quo_q[j] <= quo_d[j];
        den_q[j] <= (j == 0) ? den_i : den_q[j-1];
        side_q[j] <= (j == 0) ? side_i : side_q[j-1];
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign ratio_o = quo_q[QW-1];
  assign side_o = side_q[QW-1];
endmodule

>>> rtl/a2ba_eval.sv
// Angle evaluation: rational path with pipelined divider, Horner polynomial path, output.
module a2ba_eval (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 precise_i,
  input  logic                 valid_i,
  input  logic [a2ba_pkg::QW-1:0] ratio_i,
  input  a2ba_pkg::side_t      side_i,
  output logic                 valid_o,
  output logic signed [a2ba_pkg::AW-1:0] angle_o
);
  import a2ba_pkg::*;

  localparam int NS = DW + 1;

  logic e1_vld_q;
  side_t e1_side_q;
  logic [QW-1:0] e1_r_q, e1_r2_q;
  logic [59:0] e1_rk_q;

  logic [NS-1:0] vld_q;
  side_t side_q [NS];
  logic [30:0] dv_q [NS];
  logic [30:0] rr_q [NS];
  logic [DW-1:0] lo_q [NS];
  logic [DW-1:0] qq_q [NS];
  logic [30:0] rr_d [NS];
  logic [DW-1:0] qq_d [NS];

  logic [QW-1:0] pr2_q [4];
  logic [QW-1:0] pr_q [4];
  logic signed [32:0] acc1_q, acc2_q, acc3_q, acc4_q, p_q;
  logic signed [AW-1:0] pf_q [5:NS-1];

  logic [61:0] rr2_full;
  logic [59:0] rc_full;
  logic [32:0] pmag;
  logic [61:0] pk_full;
  logic signed [AW-1:0] pf_d;

  logic [DW-1:0] m;
  logic signed [AW-1:0] rat_fold, fold;
  logic signed [AW:0] sum;
  logic signed [AW-1:0] angle_d, angle_q;
  logic valid_q;

  assign rr2_full = 62'(ratio_i) * 62'(ratio_i);
  assign rc_full = 60'(RAT_C_Q30) * 60'(e1_r2_q);

  always_comb begin
    for (int j = 0; j < NS; j++) begin
      logic [31:0] t;
      if (j == 0) begin
        rr_d[j] = 31'(e1_rk_q[59:30]);
        qq_d[j] = '0;
      end else begin
        t = {rr_q[j-1], lo_q[j-1][DW-1]};
        if (t >= {1'b0, dv_q[j-1]}) begin
          rr_d[j] = 31'(t - {1'b0, dv_q[j-1]});
          qq_d[j] = {qq_q[j-1][DW-2:0], 1'b1};
        end else begin
          rr_d[j] = t[30:0];
          qq_d[j] = {qq_q[j-1][DW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    pmag = p_q[32] ? 33'(-p_q) : 33'(p_q);
    pk_full = 62'(pmag[31:0]) * 62'(SCALE_Q16);
    pf_d = AW'(pk_full >> 46);
    if (p_q[32] ^ side_q[4].neg) begin
      pf_d = -pf_d;
    end
  end

  always_comb begin
    m = qq_q[NS-1];
    if (!side_q[NS-1].neg) begin
      rat_fold = AW'((31'(m) + 31'd32768) >> 16);
    end else if (m > DW'(32768)) begin
      rat_fold = -AW'((m - DW'(32768)) >> 16);
    end else begin
      rat_fold = '0;
    end
    fold = precise_i ? pf_q[NS-1] : rat_fold;
    sum = (AW+1)'(fold);
    unique case (side_q[NS-1].off)
      OFF_PLUS:  sum = sum + (AW+1)'(ANG_QUARTER_PI);
      OFF_MINUS: sum = sum - (AW+1)'(ANG_QUARTER_PI);
      default:   sum = sum;
    endcase
    if (side_q[NS-1].yneg) begin
      sum = sum + (AW+1)'(ANG_PI);
    end
    angle_d = side_q[NS-1].special ? side_q[NS-1].spec_angle : sum[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q <= 1'b0;
      vld_q <= '0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      e1_vld_q <= valid_i;
      vld_q <= {vld_q[NS-2:0], e1_vld_q};
      valid_q <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_side_q <= side_i;
      e1_r_q <= ratio_i;
      e1_r2_q <= QW'(rr2_full >> 30);
      e1_rk_q <= 60'(61'(ratio_i) * 61'(SCALE_Q16));
      for (int j = 0; j < NS; j++) begin
        side_q[j] <= (j == 0) ? e1_side_q : side_q[j-1];
        rr_q[j] <= rr_d[j];
        qq_q[j] <= qq_d[j];
        dv_q[j] <= (j == 0) ? (ONE_Q30 + 31'(rc_full >> 30)) : dv_q[j-1];
        lo_q[j] <= (j == 0) ? e1_rk_q[DW-1:0] : {lo_q[j-1][DW-2:0], 1'b0};
      end
      for (int j = 0; j < 4; j++) begin
        pr2_q[j] <= (j == 0) ? e1_r2_q : pr2_q[j-1];
        pr_q[j] <= (j == 0) ? e1_r_q : pr_q[j-1];
      end
      acc1_q <= POLY_C3 + mulq(POLY_C4, e1_r2_q);
      acc2_q <= POLY_C2 + mulq(acc1_q, pr2_q[0]);
      acc3_q <= POLY_C1 + mulq(acc2_q, pr2_q[1]);
      acc4_q <= POLY_C0 + mulq(acc3_q, pr2_q[2]);
      p_q <= mulq(acc4_q, pr_q[3]);
      pf_q[5] <= pf_d;
      for (int j = 6; j < NS; j++) begin
        pf_q[j] <= pf_q[j-1];
      end
      angle_q <= angle_d;
    end
  end

  assign valid_o = valid_q;
  assign angle_o = angle_q;
endmodule

>>> rtl/atan2_binary_angle.sv
// Top level of the angle extractor: config register, stall control and the three pipeline parts.
// Path of a request: input register, ratio divider stages, multiply register, rational
// divider stages and output register.
// Throughput: one request per cycle; the whole pipeline holds while a result waits untaken.
// Reset: asynchronous, active low; clears all valid bits and sets precise_q to 0.
module atan2_binary_angle (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [a2ba_pkg::IW-1:0] x_value_i,
  input  logic [a2ba_pkg::IW-1:0] y_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [a2ba_pkg::AW-1:0] angle_o
);
  import a2ba_pkg::*;
  `include "atan2_binary_angle_macros.svh"

  logic precise_q;
  logic en;
  logic p_valid, d_valid;
  logic [MW-1:0] p_num, p_den;
  side_t p_side, d_side;
  logic [QW-1:0] d_ratio;

  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      precise_q <= 1'b0;
    end else if (cfg_we_i) begin
      precise_q <= cfg_wdata_i;
    end
  end

  a2ba_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .x_i     (x_value_i),
    .y_i     (y_value_i),
    .valid_o (p_valid),
    .num_o   (p_num),
    .den_o   (p_den),
    .side_o  (p_side)
  );

  a2ba_ratio_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_valid),
    .num_i   (p_num),
    .den_i   (p_den),
    .side_i  (p_side),
    .valid_o (d_valid),
    .ratio_o (d_ratio),
    .side_o  (d_side)
  );

  a2ba_eval u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .precise_i (precise_q),
    .valid_i   (d_valid),
    .ratio_i   (d_ratio),
    .side_i    (d_side),
    .valid_o   (out_valid_o),
    .angle_o   (angle_o)
  );

  `A2BA_ASSERT(stall_holds_input, clk_i, rst_ni, (out_valid_o && !out_ready_i) |-> !in_ready_o)
  `A2BA_ASSERT_NR(angle_in_range, clk_i, out_valid_o |-> (angle_o >= -17'sd16384 && angle_o <= 17'sd49152))
  `A2BA_ASSERT(empty_after_reset, clk_i, rst_ni, !$past(rst_ni) |-> !out_valid_o)
endmodule

>>> tb/atan2_binary_angle_tb.sv
// Self-checking testbench for the angle extractor: directed table, then random traffic.
module atan2_binary_angle_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import a2ba_pkg::*;

  localparam int WATCH_LIMIT = 5000;
  localparam int LATENCY = 65;
  localparam longint K16 = 683565276;
  localparam longint RAT_C = 300647711;
  localparam longint ONE_Q = 1073741824;

  typedef struct {
    logic [IW-1:0] x;
    logic [IW-1:0] y;
    bit mode;
    bit fixed;
    logic signed [AW-1:0] angle;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [IW-1:0] x_value_i = '0;
  logic [IW-1:0] y_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [AW-1:0] angle_o;

  bit fixed_i = 1'b0;
  logic signed [AW-1:0] fixed_angle_i = '0;
  bit mode_now = 1'b0;
  bit stall_on = 1'b1;

  logic signed [AW-1:0] angle_q[$];
  int errors = 0;
  int n_req = 0;
  int n_res = 0;
  int idle_cycles = 0;

  atan2_binary_angle uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .x_value_i(x_value_i), .y_value_i(y_value_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .angle_o(angle_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    longint unsigned m;
    m = (mag(a) * mag(b)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint q30_ratio(longint num, longint den);
    longint unsigned m;
    m = (mag(num) << 30) / mag(den);
    return ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint folded_angle(longint r, bit mode);
    longint r2, acc, p, v;
    longint unsigned d, m;
    r2 = q30_mul(r, r);
    if (!mode) begin
      d = ONE_Q + q30_mul(RAT_C, r2);
      m = (mag(r) * K16) / d;
      v = r < 0 ? -longint'(m) : longint'(m);
      return (v + 32768) / 65536;
    end
    acc = 22371508;
    acc = -91410863 + q30_mul(acc, r2);
    acc = 193424926 + q30_mul(acc, r2);
    acc = -354656388 + q30_mul(acc, r2);
    acc = 1073597943 + q30_mul(acc, r2);
    p = q30_mul(acc, r);
    m = (mag(p) * K16) >> 46;
    return p < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [AW-1:0] angle_predict(logic [IW-1:0] xb, logic [IW-1:0] yb,
                                                         bit mode);
    longint x, y, a;
    x = longint'($signed(xb));
    y = longint'($signed(yb));
    if (y == 0) begin
      a = x > 0 ? 16384 : (x < 0 ? -16384 : 0);
    end else begin
      if (mag(x) <= mag(y)) a = folded_angle(q30_ratio(x, y), mode);
      else if ((x < 0) == (y < 0)) a = folded_angle(q30_ratio(x - y, x + y), mode) + 8192;
      else a = folded_angle(q30_ratio(x + y, y - x), mode) - 8192;
      if (y < 0) a += 32768;
    end
    return AW'(a);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid_i && in_ready_o) begin
        n_req <= n_req + 1;
        angle_q.push_back(fixed_i ? fixed_angle_i : angle_predict(x_value_i, y_value_i, mode_now));
      end
      if (out_valid_o && out_ready_i) begin
        n_res <= n_res + 1;
        if (angle_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result angle=%0d", angle_o);
        end else if (angle_o !== angle_q[0]) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %0d, got %0d", angle_q[0], angle_o);
          void'(angle_q.pop_front());
        end else begin
          void'(angle_q.pop_front());
        end
      end
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("timeout: no progress for %0d cycles", WATCH_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    int r, hold;
    if (!stall_on) begin
      out_ready_i <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      hold = r < 60 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40));
      if (hold == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic drain_and_set(bit mode);
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_now = mode;
  endtask

  task automatic send(logic [IW-1:0] x, logic [IW-1:0] y, bit fx, logic signed [AW-1:0] fa,
                      bit gaps);
    int r, gap;
    in_valid_i <= 1'b1;
    x_value_i <= x;
    y_value_i <= y;
    fixed_i <= fx;
    fixed_angle_i <= fa;
    do @(posedge clk_i); while (!in_ready_o);
    r = $urandom_range(0, 99);
    gap = !gaps ? 0 : (r < 65 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [IW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h8000;
    if (r < 16) return 16'h7FFF;
    if (r < 22) return '0;
    if (r < 35) return IW'($signed($urandom_range(0, 16)) - 8);
    return IW'($urandom());
  endfunction

  task automatic random_phase(int count, bit gaps);
    logic [IW-1:0] x, y;
    int r;
    repeat (count) begin
      x = pick_value();
      y = pick_value();
      r = $urandom_range(0, 99);
      if (r < 6) y = x;
      else if (r < 12) y = -x;
      else if (r < 16) y = '0;
      send(x, y, 1'b0, '0, gaps);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  dir_row_t dir_rows[] = '{
    '{16'h0001, 16'h0000, 0, 1, 17'sd16384},
    '{16'hFFFF, 16'h0000, 0, 1, -17'sd16384},
    '{16'h0000, 16'h0000, 0, 1, 17'sd0},
    '{16'h7FFF, 16'h0000, 0, 1, 17'sd16384},
    '{16'h8000, 16'h0000, 0, 1, -17'sd16384},
    '{16'h0000, 16'h0001, 0, 1, 17'sd0},
    '{16'h0000, 16'hFFFF, 0, 1, 17'sd32768},
    '{16'h7FFF, 16'h7FFF, 0, 0, 0},
    '{16'h8000, 16'h8000, 0, 0, 0},
    '{16'h7FFF, 16'h8000, 0, 0, 0},
    '{16'h8000, 16'h7FFF, 0, 0, 0},
    '{16'h7FFF, 16'h0001, 0, 0, 0},
    '{16'h8000, 16'hFFFF, 0, 0, 0},
    '{16'h0001, 16'h8000, 0, 0, 0},
    '{16'h0003, 16'hFFFC, 0, 0, 0},
    '{16'h0000, 16'h0001, 1, 1, 17'sd0},
    '{16'h0000, 16'h8000, 1, 1, 17'sd32768},
    '{16'hFFFF, 16'h0000, 1, 1, -17'sd16384},
    '{16'h7FFF, 16'h7FFF, 1, 0, 0},
    '{16'h8000, 16'h7FFF, 1, 0, 0},
    '{16'h7FFF, 16'h8001, 1, 0, 0},
    '{16'h8000, 16'h0001, 1, 0, 0},
    '{16'h1234, 16'hEDCC, 1, 0, 0},
    '{16'h0001, 16'h7FFF, 1, 0, 0}
  };

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != mode_now) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        drain_and_set(dir_rows[i].mode);
      end
      send(dir_rows[i].x, dir_rows[i].y, dir_rows[i].fixed, dir_rows[i].angle, 1'b1);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    drain_and_set(1'b0);
    random_phase(400, 1'b1);
    drain_and_set(1'b1);
    random_phase(400, 1'b1);
    stall_on = 1'b0;
    drain_and_set(1'b0);
    random_phase(200, 1'b0);
    stall_on = 1'b1;
    drain_and_set(1'b1);
    random_phase(200, 1'b1);
    while (angle_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    $display("covered %0d requests and %0d results over both approximation modes,", n_req, n_res);
    $display("with zero denominators, unit ratios, extremes and random stalls");
    if (errors == 0 && angle_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
